/* rtl/core/dtl_pkg.sv */
// ----------------------------------------------------------------------------
// dtl_pkg
// Shared types and constants of the delta timeout list: entry count, field
// widths, the entry store request and read data, and the shared unit opcodes.
// ----------------------------------------------------------------------------
package dtl_pkg;

    localparam int ENTRIES = 64;
    localparam int HW      = 7;
    localparam int IW      = $clog2(ENTRIES);
    localparam int DW      = 31;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_POP    = 2'd2;

    typedef enum logic [0:0] {
        ALU_SUB     = 1'b0,
        ALU_ADD_SAT = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic [IW-1:0] rd_addr;
        logic          we_next;
        logic [IW-1:0] wa_next;
        logic [HW-1:0] wd_next;
        logic          we_prev;
        logic [IW-1:0] wa_prev;
        logic [HW-1:0] wd_prev;
        logic          we_delta;
        logic [IW-1:0] wa_delta;
        logic [DW-1:0] wd_delta;
    } t_mem_req;

    typedef struct packed {
        logic [HW-1:0] next;
        logic [HW-1:0] prev;
        logic [DW-1:0] delta;
    } t_mem_rd;

    function automatic logic [IW-1:0] to_index(input logic [HW-1:0] h);
        logic [HW-1:0] t;
        t = h - {{(HW-1){1'b0}}, 1'b1};
        return t[IW-1:0];
    endfunction

    function automatic logic handle_ok(input logic [HW-1:0] h);
        return (h != '0) && (h <= ENTRIES[HW-1:0]);
    endfunction

endpackage

/* rtl/core/dtl_ram.sv */
// ----------------------------------------------------------------------------
// dtl_ram
// Entry store: next link, previous link and delta per entry, one write port
// per array and one shared registered read address.
// ----------------------------------------------------------------------------
module dtl_ram (
    input  logic              i_clk,
    input  dtl_pkg::t_mem_req i_req,
    output dtl_pkg::t_mem_rd  o_rd
);
    import dtl_pkg::*;

    logic [HW-1:0] r_next_mem  [ENTRIES];
    logic [HW-1:0] r_prev_mem  [ENTRIES];
    logic [DW-1:0] r_delta_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_req.we_next) begin
            r_next_mem[i_req.wa_next] <= i_req.wd_next;
        end
        if (i_req.we_prev) begin
            r_prev_mem[i_req.wa_prev] <= i_req.wd_prev;
        end
        if (i_req.we_delta) begin
            r_delta_mem[i_req.wa_delta] <= i_req.wd_delta;
        end
        o_rd.next  <= r_next_mem[i_req.rd_addr];
        o_rd.prev  <= r_prev_mem[i_req.rd_addr];
        o_rd.delta <= r_delta_mem[i_req.rd_addr];
    end

endmodule

/* rtl/core/dtl_alu.sv */
// ----------------------------------------------------------------------------
// dtl_alu
// Shared delta unit: subtract with borrow for the walk compare and relink,
// saturating add for remove.
// ----------------------------------------------------------------------------
module dtl_alu (
    input  dtl_pkg::t_alu_op    i_op,
    input  logic [dtl_pkg::DW-1:0] i_a,
    input  logic [dtl_pkg::DW-1:0] i_b,
    output logic [dtl_pkg::DW-1:0] o_res,
    output logic                o_borrow
);
    import dtl_pkg::*;

    logic [DW:0] diff;
    logic [DW:0] sum;

    assign diff = {1'b0, i_a} - {1'b0, i_b};
    assign sum  = {1'b0, i_a} + {1'b0, i_b};

    always_comb begin
        o_borrow = diff[DW];
        case (i_op)
            ALU_SUB:     o_res = diff[DW-1:0];
            ALU_ADD_SAT: o_res = sum[DW] ? {DW{1'b1}} : sum[DW-1:0];
            default:     o_res = diff[DW-1:0];
        endcase
    end

endmodule

/* rtl/core/delta_timeout_list.sv */
// ----------------------------------------------------------------------------
// delta_timeout_list
// Delta list of task entries ordered by timeout, with insert, remove and pop.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives exactly one result. Insert walks
// the list, reading one entry per cycle through the single read port of the
// entry store and comparing in the shared delta unit, then links the entry
// in; remove reads the entry and, if it has a successor, that one too; pop
// unlinks the head; an invalid handle or a rejected insert goes straight to
// the result, which may wait for the previous result to be taken. No clearing
// pass is needed after reset: links and deltas are written before they are
// read.
module delta_timeout_list (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_action,
    input  logic [dtl_pkg::HW-1:0] i_handle,
    input  logic [dtl_pkg::DW-1:0] i_delay,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_status,
    output logic [dtl_pkg::HW-1:0] o_popped_handle
);
    import dtl_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DISP  = 9'b000000010,
        S_WALK  = 9'b000000100,
        S_LINK  = 9'b000001000,
        S_LINK2 = 9'b000010000,
        S_RM_A  = 9'b000100000,
        S_RM_B  = 9'b001000000,
        S_POP   = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state        r_state, n_state;
    logic [1:0]    r_act;
    logic [HW-1:0] r_hdl;
    logic [DW-1:0] r_to, n_to;
    logic [HW-1:0] r_p, n_p;
    logic [HW-1:0] r_q, n_q;
    logic [DW-1:0] r_pd, n_pd;
    logic [HW-1:0] r_nxt, n_nxt;
    logic [HW-1:0] r_prv, n_prv;
    logic [DW-1:0] r_dh, n_dh;
    logic [HW-1:0] r_head, n_head;
    logic          r_status, n_status;
    logic [HW-1:0] r_popped, n_popped;
    logic [ENTRIES-1:0] r_waiting, n_waiting;
    logic          r_ov, n_ov;
    logic          r_ostatus, n_ostatus;
    logic [HW-1:0] r_opop, n_opop;

    t_mem_req      req;
    t_mem_rd       rd;
    t_alu_op       alu_op;
    logic [DW-1:0] alu_a, alu_b, alu_res;
    logic          alu_borrow;

    dtl_ram u_ram (
        .i_clk (i_clk),
        .i_req (req),
        .o_rd  (rd)
    );

    dtl_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_ov;
    assign o_status        = r_ostatus;
    assign o_popped_handle = r_opop;

    always_comb begin
        n_state   = r_state;
        n_to      = r_to;
        n_p       = r_p;
        n_q       = r_q;
        n_pd      = r_pd;
        n_nxt     = r_nxt;
        n_prv     = r_prv;
        n_dh      = r_dh;
        n_head    = r_head;
        n_status  = r_status;
        n_popped  = r_popped;
        n_waiting = r_waiting;
        n_ov      = r_ov;
        n_ostatus = r_ostatus;
        n_opop    = r_opop;
        req       = '0;
        alu_op    = ALU_SUB;
        alu_a     = r_to;
        alu_b     = rd.delta;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_to    = i_delay;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_status = 1'b0;
                n_popped = '0;
                n_state  = S_FIN;
                case (r_act)
                    ACT_INSERT: begin
                        if (handle_ok(r_hdl)) begin
                            if (r_waiting[to_index(r_hdl)]) begin
                                n_status = 1'b1;
                            end else begin
                                n_p = r_head;
                                n_q = '0;
                                req.rd_addr = to_index(r_head);
                                n_state = (r_head == '0) ? S_LINK : S_WALK;
                            end
                        end
                    end
                    ACT_REMOVE: begin
                        if (handle_ok(r_hdl) && r_waiting[to_index(r_hdl)]) begin
                            req.rd_addr = to_index(r_hdl);
                            n_state     = S_RM_A;
                        end
                    end
                    ACT_POP: begin
                        if (r_head != '0) begin
                            req.rd_addr = to_index(r_head);
                            n_state     = S_POP;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_WALK: begin
                if (!alu_borrow && (alu_res != '0)) begin
                    n_to        = alu_res;
                    n_q         = r_p;
                    n_p         = rd.next;
                    req.rd_addr = to_index(rd.next);
                    if (rd.next == '0) begin
                        n_state = S_LINK;
                    end
                end else begin
                    n_pd    = rd.delta;
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                req.we_next  = 1'b1;
                req.wa_next  = to_index(r_hdl);
                req.wd_next  = r_p;
                req.we_prev  = 1'b1;
                req.wa_prev  = to_index(r_hdl);
                req.wd_prev  = r_q;
                req.we_delta = 1'b1;
                req.wa_delta = to_index(r_hdl);
                req.wd_delta = r_to;
                n_waiting[to_index(r_hdl)] = 1'b1;
                n_state = S_LINK2;
            end
            S_LINK2: begin
                alu_a = r_pd;
                alu_b = r_to;
                if (r_p != '0) begin
                    req.we_delta = 1'b1;
                    req.wa_delta = to_index(r_p);
                    req.wd_delta = alu_res;
                    req.we_prev  = 1'b1;
                    req.wa_prev  = to_index(r_p);
                    req.wd_prev  = r_hdl;
                end
                if (r_q != '0) begin
                    req.we_next = 1'b1;
                    req.wa_next = to_index(r_q);
                    req.wd_next = r_hdl;
                end else begin
                    n_head = r_hdl;
                end
                n_state = S_FIN;
            end
            S_RM_A: begin
                n_nxt = rd.next;
                n_prv = rd.prev;
                n_dh  = rd.delta;
                if (rd.next == '0) begin
                    if (rd.prev != '0) begin
                        req.we_next = 1'b1;
                        req.wa_next = to_index(rd.prev);
                        req.wd_next = '0;
                    end
                    if (r_head == r_hdl) begin
                        n_head = '0;
                    end
                    n_waiting[to_index(r_hdl)] = 1'b0;
                    n_state = S_FIN;
                end else begin
                    req.rd_addr = to_index(rd.next);
                    n_state     = S_RM_B;
                end
            end
            S_RM_B: begin
                alu_op       = ALU_ADD_SAT;
                alu_a        = rd.delta;
                alu_b        = r_dh;
                req.we_prev  = 1'b1;
                req.wa_prev  = to_index(r_nxt);
                req.wd_prev  = r_prv;
                req.we_delta = 1'b1;
                req.wa_delta = to_index(r_nxt);
                req.wd_delta = alu_res;
                if (r_prv != '0) begin
                    req.we_next = 1'b1;
                    req.wa_next = to_index(r_prv);
                    req.wd_next = r_nxt;
                end
                if (r_head == r_hdl) begin
                    n_head = r_nxt;
                end
                n_waiting[to_index(r_hdl)] = 1'b0;
                n_state = S_FIN;
            end
            S_POP: begin
                n_head   = rd.next;
                n_popped = r_head;
                n_waiting[to_index(r_head)] = 1'b0;
                if (rd.next != '0) begin
                    req.we_prev = 1'b1;
                    req.wa_prev = to_index(rd.next);
                    req.wd_prev = '0;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ov || i_out_ready) begin
                    n_ov      = 1'b1;
                    n_ostatus = r_status;
                    n_opop    = r_popped;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_waiting <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_waiting <= n_waiting;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_act <= i_action;
            r_hdl <= i_handle;
        end
        r_to      <= n_to;
        r_p       <= n_p;
        r_q       <= n_q;
        r_pd      <= n_pd;
        r_nxt     <= n_nxt;
        r_prv     <= n_prv;
        r_dh      <= n_dh;
        r_status  <= n_status;
        r_popped  <= n_popped;
        r_ostatus <= n_ostatus;
        r_opop    <= n_opop;
    end

endmodule
